// ===== src/packet_sequence_reorder_window_assert.svh =====
// Assertion macros for the checker file of the reorder window.
`ifndef PACKET_SEQUENCE_REORDER_WINDOW_ASSERT_SVH
`define PACKET_SEQUENCE_REORDER_WINDOW_ASSERT_SVH

// Plain property on the clock, off while reset is active.
`define PSRW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("reorder window assertion failed");

// Signal must keep its value in the cycle after cond holds.
`define PSRW_HOLD(name, clk, rst_n, cond, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error("reorder window output changed while stalled");

`endif

// ===== src/psrw_pkg.sv =====
// ----------------------------------------------------------------------------
// psrw_pkg
// Shared types and codes of the packet sequence reorder window.
// ----------------------------------------------------------------------------
package psrw_pkg;

  localparam int TDATA_W = 56;
  localparam int ITEM_W  = 50;

  typedef enum logic [1:0] {
    EV_DELIVER  = 2'd0,
    EV_KEYFRAME = 2'd1,
    EV_RESYNC   = 2'd2
  } ev_kind_e;

  // Packed so that chan sits in the lowest bits, same as the stream tdata.
  typedef struct packed {
    logic [15:0] length;
    logic [15:0] handle;
    logic [15:0] seq;
    logic [1:0]  chan;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_INORDER,
    ST_DRAIN_RD,
    ST_DRAIN_EMIT,
    ST_AHEAD,
    ST_SCAN,
    ST_RESYNC,
    ST_JUMP_RESYNC,
    ST_JUMP_DELIVER
  } state_e;

endpackage

// ===== src/packet_sequence_reorder_window.sv =====
// ----------------------------------------------------------------------------
// packet_sequence_reorder_window
// Reorders packet descriptors by sequence number on several channels.
// ----------------------------------------------------------------------------
// Descriptors enter a two-item queue; ignored ones (zero length, unknown
// channel) are dropped there. The engine takes one item at a time: it
// classifies it, then drops a duplicate, delivers an in-order item, holds
// one ahead, or on a jump of a whole window emits a resync, then delivers.
// Each held packet drained behind an item adds a store read, then an output.
// A store-full resync scans window slots from the head, up to WINDOW_SLOTS,
// then emits the resync event. Output backpressure stalls the engine, the
// queue keeps taking items until full. No clearing pass follows reset.
module packet_sequence_reorder_window #(
  parameter int CHANNELS     = 4,
  parameter int WINDOW_SLOTS = 64,
  parameter int STORE_LIMIT  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // channel, seq, packet_handle, packet_length
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // event_channel, event_seq, out_handle, out_length
  output logic [1:0]  m_axis_tuser,   // event_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // keyframe_request_enable
);

  logic            kfe_q;
  logic            item_valid, item_ready;
  psrw_pkg::item_t in_item, item;

  assign cfg_ready_o = 1'b1;
  assign in_item     = s_axis_tdata[psrw_pkg::ITEM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kfe_q <= 1'b1;
    end else if (cfg_valid_i) begin
      kfe_q <= cfg_data_i;
    end
  end

  psrw_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .item_valid_o(item_valid),
    .item_ready_i(item_ready),
    .item_o      (item)
  );

  psrw_engine #(
    .CHANNELS    (CHANNELS),
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .STORE_LIMIT (STORE_LIMIT)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_i      (item),
    .kfe_i       (kfe_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== src/psrw_front.sv =====
// ----------------------------------------------------------------------------
// psrw_front
// Input side: takes descriptors, drops ignored ones, queues the rest.
// ----------------------------------------------------------------------------
module psrw_front #(
  parameter int CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  psrw_pkg::item_t                   in_item_i,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output psrw_pkg::item_t                   item_o
);

  psrw_pkg::item_t fifo_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      count_q;
  logic            keep, push, pop;

  // zero length or out-of-range channel: ignored
  assign keep = (in_item_i.length != 16'd0) &&
                ({30'd0, in_item_i.chan} < 32'(CHANNELS));

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o && keep;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = fifo_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= in_item_i;
  end

endmodule

// ===== src/psrw_engine.sv =====
// ----------------------------------------------------------------------------
// psrw_engine
// Per-channel sequence tracking, early packet store and event output.
// ----------------------------------------------------------------------------
module psrw_engine #(
  parameter int CHANNELS     = 4,
  parameter int WINDOW_SLOTS = 64,
  parameter int STORE_LIMIT  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  psrw_pkg::item_t                 item_i,
  input  logic                            kfe_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [psrw_pkg::TDATA_W-1:0]    out_data_o,
  output logic [1:0]                      out_kind_o,
  output logic                            out_last_o
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = $clog2(WINDOW_SLOTS);
  localparam int HW = $clog2(STORE_LIMIT + 1);
  localparam int AW = CW + SW;
  localparam logic [SW:0] WS_W = (SW + 1)'(WINDOW_SLOTS);

  function automatic logic [SW-1:0] wrap_add(logic [SW-1:0] a, logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WS_W) s = s - WS_W;
    return s[SW-1:0];
  endfunction

  psrw_pkg::state_e state_q, state_d;

  psrw_pkg::item_t   item_q;
  logic [CW-1:0]     ch_q;
  logic [15:0]       u_q;
  logic [SW-1:0]     d_q;
  logic              found_q;

  logic              started_q [CHANNELS];
  logic [15:0]       exp_q     [CHANNELS];
  logic              gap_q     [CHANNELS];
  logic [SW-1:0]     head_q    [CHANNELS];
  logic [HW-1:0]     held_q    [CHANNELS];
  logic [WINDOW_SLOTS-1:0] occ_q [CHANNELS];

  logic [31:0]       mem_q [2**AW];
  logic [31:0]       rdata_q;

  logic              ovalid_q;
  logic [psrw_pkg::TDATA_W-1:0] odata_q;
  logic [1:0]        okind_q;
  logic              olast_q;

  logic [15:0]       exp_cur, exp_eff, u_calc;
  logic [SW-1:0]     head_cur, head_inc, slot_u, slot_d;
  logic [HW-1:0]     held_cur, held_dec, held_after;
  logic [WINDOW_SLOTS-1:0] occ_cur;
  logic              gap_cur, out_free, inord_more, drain_more, slot_free;
  logic              ahead_full, kf_emit, ahead_go, scan_hit, scan_end;

  logic              emit_en, emit_last;
  psrw_pkg::ev_kind_e emit_kind;
  logic [15:0]       emit_seq, emit_handle, emit_len;

  assign exp_cur    = exp_q[ch_q];
  assign head_cur   = head_q[ch_q];
  assign held_cur   = held_q[ch_q];
  assign gap_cur    = gap_q[ch_q];
  assign occ_cur    = occ_q[ch_q];
  assign exp_eff    = started_q[ch_q] ? exp_cur : item_q.seq;
  assign u_calc     = item_q.seq - exp_eff;
  assign head_inc   = wrap_add(head_cur, SW'(1));
  assign slot_u     = wrap_add(head_cur, u_q[SW-1:0]);
  assign slot_d     = wrap_add(head_cur, d_q);
  assign out_free   = !ovalid_q || out_ready_i;
  assign inord_more = (held_cur != '0) && occ_cur[head_inc];
  assign held_dec   = held_cur - HW'(1);
  assign drain_more = (held_dec != '0) && occ_cur[head_inc];
  assign slot_free  = !occ_cur[slot_u];
  assign held_after = held_cur + HW'(slot_free);
  assign ahead_full = held_after >= HW'(STORE_LIMIT);
  assign kf_emit    = !gap_cur && kfe_i;
  assign ahead_go   = !kf_emit || out_free;
  assign scan_hit   = occ_cur[slot_d];
  assign scan_end   = (d_q == SW'(WINDOW_SLOTS - 1));

  assign item_ready_o = (state_q == psrw_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      psrw_pkg::ST_IDLE: begin
        if (item_valid_i) state_d = psrw_pkg::ST_CLASSIFY;
      end
      psrw_pkg::ST_CLASSIFY: begin
        if (u_calc == 16'd0) state_d = psrw_pkg::ST_INORDER;
        else if (u_calc[15]) state_d = psrw_pkg::ST_IDLE;
        else if (u_calc < 16'(WINDOW_SLOTS)) state_d = psrw_pkg::ST_AHEAD;
        else state_d = psrw_pkg::ST_JUMP_RESYNC;
      end
      psrw_pkg::ST_INORDER: begin
        if (out_free) state_d = inord_more ? psrw_pkg::ST_DRAIN_RD : psrw_pkg::ST_IDLE;
      end
      psrw_pkg::ST_DRAIN_RD: state_d = psrw_pkg::ST_DRAIN_EMIT;
      psrw_pkg::ST_DRAIN_EMIT: begin
        if (out_free) state_d = drain_more ? psrw_pkg::ST_DRAIN_RD : psrw_pkg::ST_IDLE;
      end
      psrw_pkg::ST_AHEAD: begin
        if (ahead_go) state_d = ahead_full ? psrw_pkg::ST_SCAN : psrw_pkg::ST_IDLE;
      end
      psrw_pkg::ST_SCAN: begin
        if (scan_hit || scan_end) state_d = psrw_pkg::ST_RESYNC;
      end
      psrw_pkg::ST_RESYNC: begin
        if (out_free) state_d = found_q ? psrw_pkg::ST_DRAIN_RD : psrw_pkg::ST_IDLE;
      end
      psrw_pkg::ST_JUMP_RESYNC: begin
        if (out_free) state_d = psrw_pkg::ST_JUMP_DELIVER;
      end
      psrw_pkg::ST_JUMP_DELIVER: begin
        if (out_free) state_d = psrw_pkg::ST_IDLE;
      end
      default: state_d = psrw_pkg::ST_IDLE;
    endcase
  end

  // event outputs
  always_comb begin
    emit_en     = 1'b0;
    emit_kind   = psrw_pkg::EV_DELIVER;
    emit_seq    = item_q.seq;
    emit_handle = item_q.handle;
    emit_len    = item_q.length;
    emit_last   = 1'b1;
    case (state_q)
      psrw_pkg::ST_INORDER: begin
        emit_en   = out_free;
        emit_last = !inord_more;
      end
      psrw_pkg::ST_DRAIN_EMIT: begin
        emit_en     = out_free;
        emit_seq    = exp_cur;
        emit_handle = rdata_q[31:16];
        emit_len    = rdata_q[15:0];
        emit_last   = !drain_more;
      end
      psrw_pkg::ST_AHEAD: begin
        emit_en     = kf_emit && out_free;
        emit_kind   = psrw_pkg::EV_KEYFRAME;
        emit_seq    = 16'd0;
        emit_handle = 16'd0;
        emit_len    = 16'd0;
        emit_last   = !ahead_full;
      end
      psrw_pkg::ST_RESYNC: begin
        emit_en     = out_free;
        emit_kind   = psrw_pkg::EV_RESYNC;
        emit_seq    = exp_cur + 16'(d_q);
        emit_handle = 16'd0;
        emit_len    = 16'd0;
        emit_last   = !found_q;
      end
      psrw_pkg::ST_JUMP_RESYNC: begin
        emit_en     = out_free;
        emit_kind   = psrw_pkg::EV_RESYNC;
        emit_handle = 16'd0;
        emit_len    = 16'd0;
        emit_last   = 1'b0;
      end
      psrw_pkg::ST_JUMP_DELIVER: begin
        emit_en = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= psrw_pkg::ST_IDLE;
      u_q      <= 16'd0;
      d_q      <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        started_q[c] <= 1'b0;
        exp_q[c]     <= 16'd0;
        gap_q[c]     <= 1'b0;
        head_q[c]    <= '0;
        held_q[c]    <= '0;
        occ_q[c]     <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit_en) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        psrw_pkg::ST_CLASSIFY: begin
          started_q[ch_q] <= 1'b1;
          exp_q[ch_q]     <= exp_eff;
          u_q             <= u_calc;
        end
        psrw_pkg::ST_INORDER: begin
          if (out_free) begin
            exp_q[ch_q]  <= exp_cur + 16'd1;
            head_q[ch_q] <= head_inc;
            if (!inord_more && held_cur == '0) gap_q[ch_q] <= 1'b0;
          end
        end
        psrw_pkg::ST_DRAIN_EMIT: begin
          if (out_free) begin
            occ_q[ch_q][head_cur] <= 1'b0;
            held_q[ch_q]          <= held_dec;
            exp_q[ch_q]           <= exp_cur + 16'd1;
            head_q[ch_q]          <= head_inc;
            if (!drain_more && held_dec == '0) gap_q[ch_q] <= 1'b0;
          end
        end
        psrw_pkg::ST_AHEAD: begin
          if (ahead_go) begin
            gap_q[ch_q] <= 1'b1;
            if (slot_free) occ_q[ch_q][slot_u] <= 1'b1;
            held_q[ch_q] <= held_after;
            d_q          <= '0;
          end
        end
        psrw_pkg::ST_SCAN: begin
          // walk the window from the head for the nearest held packet
          if (scan_hit) begin
            found_q <= 1'b1;
          end else if (scan_end) begin
            found_q <= 1'b0;
            d_q     <= '0;
          end else begin
            d_q <= d_q + SW'(1);
          end
        end
        psrw_pkg::ST_RESYNC: begin
          if (out_free) begin
            gap_q[ch_q]  <= 1'b0;
            exp_q[ch_q]  <= exp_cur + 16'(d_q);
            head_q[ch_q] <= slot_d;
          end
        end
        psrw_pkg::ST_JUMP_RESYNC: begin
          if (out_free) begin
            occ_q[ch_q]  <= '0;
            held_q[ch_q] <= '0;
            head_q[ch_q] <= '0;
            gap_q[ch_q]  <= 1'b0;
            exp_q[ch_q]  <= item_q.seq;
          end
        end
        psrw_pkg::ST_JUMP_DELIVER: begin
          if (out_free) begin
            exp_q[ch_q]  <= item_q.seq + 16'd1;
            head_q[ch_q] <= head_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == psrw_pkg::ST_IDLE && item_valid_i) begin
      item_q <= item_i;
      ch_q   <= CW'(item_i.chan);
    end
    if (emit_en) begin
      odata_q <= {6'd0, emit_len, emit_handle, emit_seq, 2'(ch_q)};
      okind_q <= emit_kind;
      olast_q <= emit_last;
    end
  end

  // early packet store: {handle, length} per channel and slot
  always_ff @(posedge clk_i) begin
    if (state_q == psrw_pkg::ST_AHEAD && ahead_go && slot_free)
      mem_q[{ch_q, slot_u}] <= {item_q.handle, item_q.length};
    if (state_q == psrw_pkg::ST_DRAIN_RD)
      rdata_q <= mem_q[{ch_q, head_cur}];
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;

endmodule

// ===== src/psrw_checker.sv =====
// ----------------------------------------------------------------------------
// psrw_checker
// Port-level checks on the event stream of the reorder window.
// ----------------------------------------------------------------------------
`include "packet_sequence_reorder_window_assert.svh"

module psrw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `PSRW_ASSERT(a_kind_legal, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tuser == psrw_pkg::EV_DELIVER || m_axis_tuser == psrw_pkg::EV_KEYFRAME || m_axis_tuser == psrw_pkg::EV_RESYNC))
  `PSRW_ASSERT(a_ctrl_no_payload, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != psrw_pkg::EV_DELIVER) |-> (m_axis_tdata[49:18] == 32'd0))
  `PSRW_ASSERT(a_keyframe_seq_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser == psrw_pkg::EV_KEYFRAME) |-> (m_axis_tdata[17:2] == 16'd0))
  `PSRW_ASSERT(a_valid_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
  `PSRW_HOLD(a_last_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready), m_axis_tlast)

endmodule

bind packet_sequence_reorder_window psrw_checker u_psrw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
